@@ rtl/nau_pkg.sv @@
package nau_pkg;

   // Fixed-point setup
   localparam int SEGMENTS     = 256;
   localparam int IN_FRAC_BITS = 12;

   localparam int SAMPLE_W = 16;
   localparam int RESULT_W = 32;
   localparam int MODE_W   = 3;

   // Table point index, wide enough to address point SEGMENTS
   localparam int IDX_W  = $clog2(SEGMENTS + 1);
   localparam int FRAC_W = 16;
   localparam int POS_W  = FRAC_W + IDX_W;

   // Table words hold Q16 values in [-1.0, 1.0]
   localparam int ROM_W  = 18;
   localparam int DIFF_W = ROM_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;
   localparam int MULT_W = 2 * ROM_W;

   localparam int LIN_SHIFT = 16 - IN_FRAC_BITS;
   localparam int DSQ_SHIFT = 17 - IN_FRAC_BITS;
   localparam int SQ_SHIFT  = 2 * IN_FRAC_BITS - 16;
   localparam int SQ_HALF   = (1 << SQ_SHIFT) >> 1;

   // Sample position scale for table construction
   localparam real X_SCALE = 1.0 / ((2.0 ** IN_FRAC_BITS) * SEGMENTS);

   typedef enum logic [MODE_W-1:0] {
      MODE_LINEAR  = 3'd0,
      MODE_SIGMOID = 3'd1,
      MODE_RELU    = 3'd2,
      MODE_TANH    = 3'd3,
      MODE_SQUARE  = 3'd4
   } mode_type;

   typedef logic signed [ROM_W-1:0] rom_word_type;
   typedef rom_word_type rom_table_type [0:SEGMENTS];

   // Points at segment starts; the negative half mirrors the positive half
   function automatic rom_table_type build_rom(input logic is_tanh);
      rom_table_type tbl;
      real           num;
      real           xmag;
      real           val;
      longint        q;
      for (int k = 0; k <= SEGMENTS; k++) begin
         num  = real'(k) * 65536.0 - 32768.0 * real'(SEGMENTS);
         xmag = ((num < 0.0) ? -num : num) * X_SCALE;
         if (is_tanh) begin
            val = $tanh(xmag);
         end else begin
            val = 0.5 + 0.5 * $tanh(0.5 * xmag);
         end
         q = longint'($floor(val * 65536.0 + 0.5));
         if (num < 0.0) begin
            q = is_tanh ? -q : 65536 - q;
         end
         tbl[k] = ROM_W'(q);
      end
      return tbl;
   endfunction

   localparam rom_table_type SIG_ROM  = build_rom(1'b0);
   localparam rom_table_type TANH_ROM = build_rom(1'b1);

endpackage

@@ rtl/neural_activation_unit.sv @@
// Activation unit: each request word carries a signed Q4.12 sample and a
// request type (0 function, 1 derivative); the response word is the selected
// function or its derivative as signed Q15.16. The function is chosen by the
// mode register (linear, sigmoid, ReLU, tanh, square), written through the
// csr port; the user must write it only while no words are in flight, which
// the block does not enforce. Sigmoid and tanh are interpolated linearly
// between constant table points. The datapath is a six-stage pipeline: one
// word is accepted per clock while the response side does not stall it.
// Back-pressure on the response side holds the pipeline; bubbles are
// squeezed out so the request side keeps accepting while any stage is empty.
module neural_activation_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic signed [15:0]           req_sample_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [31:0]           rsp_result_value,
   input  logic                         csr_wr_en,
   input  logic [nau_pkg::MODE_W-1:0]   csr_wr_data
);
   import nau_pkg::*;

   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(32768);
   localparam logic signed [MULT_W-1:0] MULT_HALF = MULT_W'(32768);
   localparam logic signed [MULT_W-1:0] SQ_ROUND  = MULT_W'(SQ_HALF);

   mode_type mode_ff;

   // Stage valid bits and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   // Stage 1: sample position
   logic                       d1_ff;
   logic signed [SAMPLE_W-1:0] x1_ff;
   mode_type                   m1_ff;
   logic [POS_W-1:0]           pos1_ff;
   logic [POS_W-1:0]           pos1_in;

   // Stage 2: table points
   logic                       d2_ff;
   logic signed [SAMPLE_W-1:0] x2_ff;
   mode_type                   m2_ff;
   rom_word_type               a2_ff;
   logic signed [DIFF_W-1:0]   diff2_ff;
   logic [FRAC_W-1:0]          frac2_ff;
   logic [IDX_W-1:0]           idx_lo;
   logic [IDX_W-1:0]           idx_hi;
   rom_word_type               pa;
   rom_word_type               pb;

   // Stage 3: slope times weight
   logic                       d3_ff;
   logic signed [SAMPLE_W-1:0] x3_ff;
   mode_type                   m3_ff;
   rom_word_type               a3_ff;
   logic signed [PROD_W-1:0]   prod3_ff;

   // Stage 4: interpolated value
   logic                       d4_ff;
   logic signed [SAMPLE_W-1:0] x4_ff;
   mode_type                   m4_ff;
   rom_word_type               y4_ff;
   logic signed [PROD_W-1:0]   rnd3;

   // Stage 5: shared multiplier
   logic                       d5_ff;
   logic signed [SAMPLE_W-1:0] x5_ff;
   mode_type                   m5_ff;
   rom_word_type               y5_ff;
   logic signed [MULT_W-1:0]   mp5_ff;
   rom_word_type               op_a;
   rom_word_type               op_b;

   // Stage 6: output word
   logic signed [RESULT_W-1:0] res6_ff;
   logic signed [RESULT_W-1:0] res6_in;
   logic signed [MULT_W-1:0]   q16_sum;
   logic signed [MULT_W-1:0]   sq_sum;
   logic [RESULT_W-1:0]        q16_rnd;
   logic [RESULT_W-1:0]        sq_rnd;
   logic signed [RESULT_W-1:0] x_lin;
   logic signed [RESULT_W-1:0] x_dbl;
   logic signed [RESULT_W-1:0] y_ext;

   // Stall chain: a stage moves when it is empty or the next one moves
   assign en6       = !v6_ff || rsp_ready;
   assign en5       = !v5_ff || en6;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v6_ff;
   assign rsp_result_value = res6_ff;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LINEAR;
      end else if (csr_wr_en) begin
         mode_ff <= mode_type'(csr_wr_data);
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // Offset sample scaled by segment count
   assign pos1_in = POS_W'({~req_sample_value[SAMPLE_W-1], req_sample_value[SAMPLE_W-2:0]})
                    * POS_W'(SEGMENTS);

   always_ff @(posedge clock) begin
      if (en1) begin
         d1_ff   <= req_type;
         x1_ff   <= req_sample_value;
         m1_ff   <= mode_ff;
         pos1_ff <= pos1_in;
      end
   end

   // Neighboring table points
   assign idx_lo = pos1_ff[POS_W-1:FRAC_W];
   assign idx_hi = idx_lo + IDX_W'(1);
   assign pa     = (m1_ff == MODE_TANH) ? TANH_ROM[idx_lo] : SIG_ROM[idx_lo];
   assign pb     = (m1_ff == MODE_TANH) ? TANH_ROM[idx_hi] : SIG_ROM[idx_hi];

   always_ff @(posedge clock) begin
      if (en2) begin
         d2_ff    <= d1_ff;
         x2_ff    <= x1_ff;
         m2_ff    <= m1_ff;
         a2_ff    <= pa;
         diff2_ff <= DIFF_W'(pb) - DIFF_W'(pa);
         frac2_ff <= pos1_ff[FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         d3_ff    <= d2_ff;
         x3_ff    <= x2_ff;
         m3_ff    <= m2_ff;
         a3_ff    <= a2_ff;
         prod3_ff <= PROD_W'(diff2_ff) * $signed(PROD_W'({1'b0, frac2_ff}));
      end
   end

   // Round half up, floor shift by 16
   assign rnd3 = prod3_ff + PROD_HALF;

   always_ff @(posedge clock) begin
      if (en4) begin
         d4_ff <= d3_ff;
         x4_ff <= x3_ff;
         m4_ff <= m3_ff;
         y4_ff <= a3_ff + $signed(rnd3[FRAC_W +: ROM_W]);
      end
   end

   // Multiplier operands: s*(1-s), t*t or x*x
   always_comb begin
      case (m4_ff)
         MODE_SIGMOID: begin
            op_a = y4_ff;
            op_b = ROM_W'(65536) - y4_ff;
         end
         MODE_TANH: begin
            op_a = y4_ff;
            op_b = y4_ff;
         end
         default: begin
            op_a = ROM_W'(x4_ff);
            op_b = ROM_W'(x4_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         d5_ff  <= d4_ff;
         x5_ff  <= x4_ff;
         m5_ff  <= m4_ff;
         y5_ff  <= y4_ff;
         mp5_ff <= op_a * op_b;
      end
   end

   // Final rounding and function select
   assign q16_sum = mp5_ff + MULT_HALF;
   assign sq_sum  = mp5_ff + SQ_ROUND;
   assign q16_rnd = RESULT_W'(q16_sum[MULT_W-1:FRAC_W]);
   assign sq_rnd  = RESULT_W'(sq_sum >> SQ_SHIFT);
   assign x_lin   = RESULT_W'(x5_ff) <<< LIN_SHIFT;
   assign x_dbl   = RESULT_W'(x5_ff) <<< DSQ_SHIFT;
   assign y_ext   = RESULT_W'(y5_ff);

   always_comb begin
      case (m5_ff)
         MODE_SIGMOID: res6_in = d5_ff ? $signed(q16_rnd) : y_ext;
         MODE_RELU: begin
            if (x5_ff > 0) begin
               res6_in = d5_ff ? RESULT_W'(65536) : x_lin;
            end else begin
               res6_in = '0;
            end
         end
         MODE_TANH:   res6_in = d5_ff ? RESULT_W'(65536) - $signed(q16_rnd) : y_ext;
         MODE_SQUARE: res6_in = d5_ff ? x_dbl : $signed(sq_rnd);
         default:     res6_in = d5_ff ? RESULT_W'(65536) : x_lin;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         res6_ff <= res6_in;
      end
   end

endmodule

@@ bench/tb_neural_activation_unit.sv @@
module tb_neural_activation_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import nau_pkg::*;

   // Request kinds
   localparam logic REQ_FUNC  = 1'b0;
   localparam logic REQ_DERIV = 1'b1;

   // Mode codes the block treats as linear
   localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

   localparam longint ONE_Q16     = 65536;
   localparam longint HALF_Q16    = 32768;
   localparam longint FRAC_MASK   = 65535;
   localparam longint SAMPLE_BIAS = longint'(1) << (SAMPLE_W - 1);
   localparam int     LIN_SH      = 16 - IN_FRAC_BITS;
   localparam int     DBL_SH      = 17 - IN_FRAC_BITS;
   localparam int     SQR_SH      = 2 * IN_FRAC_BITS - 16;

   localparam int PIPE_DEPTH      = 6;
   localparam int HOLD_CYCLES     = 40;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int RUN_LIMIT_NS    = 500000;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic                       kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       known;   // result typed in below
      logic signed [RESULT_W-1:0] result;
   } probe_row_type;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic                       kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [RESULT_W-1:0] value;
   } due_word_type;

   // Directed words: extremes, every function and derivative, unused modes
   localparam probe_row_type PROBE_ROWS [0:24] = '{
      '{MODE_LINEAR,  REQ_FUNC,  16'sh8000, 1'b1, -32'sd524288},
      '{MODE_LINEAR,  REQ_FUNC,  16'sh7FFF, 1'b1, 32'sd524272},
      '{MODE_LINEAR,  REQ_DERIV, 16'sh0000, 1'b1, 32'sd65536},
      '{MODE_SIGMOID, REQ_FUNC,  16'sh0000, 1'b1, 32'sd32768},
      '{MODE_SIGMOID, REQ_DERIV, 16'sh0000, 1'b1, 32'sd16384},
      '{MODE_SIGMOID, REQ_FUNC,  16'sh8000, 1'b0, 32'sd0},
      '{MODE_SIGMOID, REQ_FUNC,  16'sh7FFF, 1'b0, 32'sd0},
      '{MODE_SIGMOID, REQ_DERIV, 16'sh3039, 1'b0, 32'sd0},
      '{MODE_RELU,    REQ_FUNC,  16'sh8000, 1'b1, 32'sd0},
      '{MODE_RELU,    REQ_FUNC,  16'sh0000, 1'b1, 32'sd0},
      '{MODE_RELU,    REQ_DERIV, 16'sh0000, 1'b1, 32'sd0},
      '{MODE_RELU,    REQ_DERIV, 16'sh0001, 1'b1, 32'sd65536},
      '{MODE_RELU,    REQ_FUNC,  16'sh7FFF, 1'b1, 32'sd524272},
      '{MODE_TANH,    REQ_FUNC,  16'sh0000, 1'b1, 32'sd0},
      '{MODE_TANH,    REQ_DERIV, 16'sh0000, 1'b1, 32'sd65536},
      '{MODE_TANH,    REQ_FUNC,  16'sh8000, 1'b0, 32'sd0},
      '{MODE_TANH,    REQ_DERIV, 16'sh7FFF, 1'b0, 32'sd0},
      '{MODE_SQUARE,  REQ_FUNC,  16'sh8000, 1'b1, 32'sd4194304},
      '{MODE_SQUARE,  REQ_FUNC,  16'sh7FFF, 1'b1, 32'sd4194048},
      '{MODE_SQUARE,  REQ_DERIV, 16'sh8000, 1'b1, -32'sd1048576},
      '{MODE_SQUARE,  REQ_DERIV, 16'sh7FFF, 1'b1, 32'sd1048544},
      '{MODE_SQUARE,  REQ_FUNC,  16'sh0001, 1'b1, 32'sd0},
      '{MODE_RSVD5,   REQ_FUNC,  16'sh3039, 1'b0, 32'sd0},
      '{MODE_RSVD6,   REQ_DERIV, 16'shFFFB, 1'b1, 32'sd65536},
      '{MODE_RSVD7,   REQ_FUNC,  16'sh8000, 1'b1, -32'sd524288}
   };

   // Mode per random phase; covers every register value
   localparam logic [MODE_W-1:0] PHASE_MODES [0:11] = '{
      MODE_SIGMOID, MODE_TANH, MODE_RSVD7, MODE_SQUARE, MODE_RELU, MODE_LINEAR,
      MODE_RSVD5, MODE_RSVD6, MODE_TANH, MODE_SIGMOID, MODE_SQUARE, MODE_RELU
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_type;
   logic signed [SAMPLE_W-1:0] req_sample_value;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [RESULT_W-1:0] rsp_result_value;
   logic                       csr_wr_en;
   logic [MODE_W-1:0]          csr_wr_data;

   longint            sigmoid_pts [0:SEGMENTS];
   longint            tanh_pts    [0:SEGMENTS];
   logic [MODE_W-1:0] mode_now;
   due_word_type      due_results [$];
   due_word_type      head;
   int                error_count;
   int                sent_count;
   int                taken_count;

   neural_activation_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Curve points at segment starts, Q16, negative half mirrored
   initial begin : curve_fill
      real    xr;
      real    e1;
      real    e2;
      longint sq;
      longint tq;
      for (int k = 0; k <= SEGMENTS; k++) begin
         xr = (real'(k) * 65536.0 / real'(SEGMENTS) - 32768.0) / (2.0 ** IN_FRAC_BITS);
         e1 = $exp(-((xr < 0.0) ? -xr : xr));
         e2 = e1 * e1;
         sq = longint'($floor(65536.0 / (1.0 + e1) + 0.5));
         tq = longint'($floor(65536.0 * (1.0 - e2) / (1.0 + e2) + 0.5));
         sigmoid_pts[k] = (xr < 0.0) ? ONE_Q16 - sq : sq;
         tanh_pts[k]    = (xr < 0.0) ? -tq : tq;
      end
   end

   // Interpolated curve value at x, Q16
   function automatic longint table_lookup(bit use_tanh, logic signed [SAMPLE_W-1:0] x);
      longint pos;
      longint idx;
      longint frac;
      longint lo;
      longint hi;
      pos  = (longint'(x) + SAMPLE_BIAS) * SEGMENTS;
      idx  = (pos >> 16) % SEGMENTS;
      frac = pos & FRAC_MASK;
      lo   = use_tanh ? tanh_pts[idx]     : sigmoid_pts[idx];
      hi   = use_tanh ? tanh_pts[idx + 1] : sigmoid_pts[idx + 1];
      return lo + (((hi - lo) * frac + HALF_Q16) >>> 16);
   endfunction

   // Expected response for one request under the given mode
   function automatic logic signed [RESULT_W-1:0] activation_of(
      logic [MODE_W-1:0] mode, logic kind, logic signed [SAMPLE_W-1:0] x);
      longint xv;
      longint v;
      longint r;
      xv = x;
      case (mode)
         MODE_SIGMOID: begin
            v = table_lookup(1'b0, x);
            r = (kind == REQ_DERIV) ? (v * (ONE_Q16 - v) + HALF_Q16) >>> 16 : v;
         end
         MODE_RELU: begin
            if (xv > 0) r = (kind == REQ_DERIV) ? ONE_Q16 : xv <<< LIN_SH;
            else r = 0;
         end
         MODE_TANH: begin
            v = table_lookup(1'b1, x);
            r = (kind == REQ_DERIV) ? ONE_Q16 - ((v * v + HALF_Q16) >>> 16) : v;
         end
         MODE_SQUARE: begin
            if (kind == REQ_DERIV) r = xv <<< DBL_SH;
            else r = (xv * xv + (longint'(1) <<< (SQR_SH - 1))) >>> SQR_SH;
         end
         default: begin
            r = (kind == REQ_DERIV) ? ONE_Q16 : xv <<< LIN_SH;
         end
      endcase
      return r[RESULT_W-1:0];
   endfunction

   task automatic report_error(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Offer one request word, back to back or after a random gap; log its expected response
   task automatic send_word(logic kind, logic signed [SAMPLE_W-1:0] x,
                            logic signed [RESULT_W-1:0] want);
      int gap;
      gap = (sent_count % 200 < 50) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_sample_value <= x;
      do @(posedge clock); while (!req_ready);
      due_results.push_back('{mode_now, kind, x, want});
      sent_count++;
      @(negedge clock);
   endtask

   // Stop offering and wait until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (due_results.size() != 0);
   endtask

   task automatic set_mode(logic [MODE_W-1:0] m);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mode_now = m;
   endtask

   // Response side: random stalls, two long hold-offs
   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken_count == 400 || taken_count == 1000) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = (taken_count % 170 < 40) ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken_count++;
         @(negedge clock);
      end
   end

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            report_error($sformatf("response word %0d with none outstanding",
                                   rsp_result_value));
         end else begin
            head = due_results.pop_front();
            if (rsp_result_value !== head.value) begin
               report_error($sformatf("mode %0d kind %0d x %0d: got %0d, want %0d",
                                      head.mode, head.kind, head.sample,
                                      rsp_result_value, head.value));
            end
         end
      end
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("tb_neural_activation_unit: done, errors");
      $finish;
   end

   // Stimulus
   initial begin : req_side
      probe_row_type              row;
      logic [15:0]                bits;
      logic signed [SAMPLE_W-1:0] x;
      logic                       kind;
      error_count      = 0;
      sent_count       = 0;
      taken_count      = 0;
      mode_now         = MODE_LINEAR;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_FUNC;
      req_sample_value = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = MODE_LINEAR;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i <= 24; i++) begin
         row = PROBE_ROWS[i];
         if (row.mode != mode_now) set_mode(row.mode);
         send_word(row.kind, row.sample,
                   row.known ? row.result : activation_of(mode_now, row.kind, row.sample));
      end

      // Random phases, one mode each
      for (int p = 0; p <= 11; p++) begin
         set_mode(PHASE_MODES[p]);
         repeat (ITEMS_PER_PHASE) begin
            bits = 16'($urandom);
            case ($urandom_range(0, 7))
               0: x = bits[0] ? 16'sh7FFF : 16'sh8000;      // range ends
               1: x = {{9{bits[6]}}, bits[6:0]};            // around zero
               2: x = {bits[15:8], 8'h00};                  // segment start
               3: x = {bits[15:8], 8'hFF};                  // segment end
               default: x = bits;
            endcase
            kind = 1'($urandom_range(0, 1));
            send_word(kind, x, activation_of(mode_now, kind, x));
         end
      end

      settle();
      repeat (2 * PIPE_DEPTH) @(negedge clock);
      if (error_count == 0) begin
         $display("tb_neural_activation_unit: done, clean");
      end else begin
         $display("tb_neural_activation_unit: done, errors");
      end
      $finish;
   end

endmodule
